/* sv/reac_pkg.sv */
// Package for the rotary encoder with acceleration and click detection.
// Holds the configuration and state records, button codes and register indexes.
// No dependencies.
package reac_pkg;

    localparam logic [11:0] ACCEL_TOP     = 12'd3072;
    localparam logic [11:0] ACCEL_DEC     = 12'd2;
    localparam logic [11:0] ACCEL_INC_RST = 12'd80;
    localparam int          CFG_IDX_W     = 3;
    localparam int          CFG_DATA_W    = 16;

    typedef enum logic [2:0] {
        BTN_OPEN     = 3'd0,
        BTN_CLICKED  = 3'd1,
        BTN_DOUBLE   = 3'd2,
        BTN_HELD     = 3'd3,
        BTN_RELEASED = 3'd4
    } btn_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_STEP    = 3'd0,
        CFG_ACCEL_INC    = 3'd1,
        CFG_ACCEL_EN     = 3'd2,
        CFG_DCLICK_EN    = 3'd3,
        CFG_HOLD_EN      = 3'd4,
        CFG_INTERVAL     = 3'd5,
        CFG_HOLD_CHECKS  = 3'd6,
        CFG_DCLICK_CHECK = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        half_step_mode;
        logic [11:0] accel_increment;
        logic        accel_enable;
        logic        double_click_enable;
        logic        hold_enable;
        logic [7:0]  check_interval;
        logic [15:0] hold_checks;
        logic [7:0]  double_click_checks;
    } reac_cfg_t;

    typedef struct packed {
        logic [1:0]  last_phase;
        logic [15:0] step_delta;
        logic [11:0] accel;
        logic [7:0]  interval_cnt;
        logic [15:0] key_down_cnt;
        logic [7:0]  dclick_cnt;
        btn_t        button;
    } reac_state_t;

endpackage

/* sv/reac_if.sv */
// Handshake channels of the rotary encoder block: tick input, result, config write.
// Depends on reac_pkg for widths.
interface reac_in_if;
    logic valid;
    logic ready;
    logic phase_a_level;
    logic phase_b_level;
    logic key_level;
    logic take_value;
    logic take_event;

    modport source (output valid, phase_a_level, phase_b_level, key_level, take_value,
                    take_event, input ready);
    modport sink   (input valid, phase_a_level, phase_b_level, key_level, take_value,
                    take_event, output ready);
endinterface

interface reac_out_if;
    logic              valid;
    logic              ready;
    logic signed [6:0] rotation_step;
    logic [2:0]        button_event;

    modport source (output valid, rotation_step, button_event, input ready);
    modport sink   (input valid, rotation_step, button_event, output ready);
endinterface

interface reac_cfg_if
    import reac_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/reac_step.sv */
// Next-state and result logic for one tick: quadrature decode, acceleration,
// button classification, value and event take. Depends on reac_pkg.
module reac_step
    import reac_pkg::*;
(
    input  reac_state_t       st,
    input  reac_cfg_t         cfg,
    input  logic              phase_a_level,
    input  logic              phase_b_level,
    input  logic              key_level,
    input  logic              take_value,
    input  logic              take_event,
    output reac_state_t       st_next,
    output logic signed [6:0] rotation_step,
    output logic [2:0]        button_event
);

    logic [11:0] acc_dec;
    logic [12:0] acc_sum;
    logic [1:0]  curr;
    logic [1:0]  diff;
    logic [7:0]  ic_inc;
    logic [15:0] kd_inc;
    logic [6:0]  mag;
    logic        neg;
    logic        pos;
    reac_state_t s;

    always_comb
    begin
        s = st;

        acc_dec = (st.accel >= ACCEL_DEC) ? st.accel - ACCEL_DEC : 12'd0;
        s.accel = acc_dec;

        // active-low pins: A gives 3, B toggles bit 0
        curr = {~phase_a_level, phase_a_level ^ phase_b_level};
        diff = st.last_phase - curr;
        acc_sum = {1'b0, acc_dec} + {1'b0, cfg.accel_increment};
        if (diff[0])
        begin
            s.last_phase = curr;
            s.step_delta = diff[1] ? st.step_delta + 16'd1 : st.step_delta - 16'd1;
            if (acc_sum <= {1'b0, ACCEL_TOP})
                s.accel = acc_sum[11:0];
        end

        ic_inc = (st.interval_cnt != 8'hFF) ? st.interval_cnt + 8'd1 : st.interval_cnt;
        s.interval_cnt = ic_inc;
        kd_inc = (st.key_down_cnt != 16'hFFFF) ? st.key_down_cnt + 16'd1 : st.key_down_cnt;

        if (ic_inc >= cfg.check_interval)
        begin
            s.interval_cnt = 8'd0;
            if (!key_level)
            begin
                s.key_down_cnt = kd_inc;
                if (kd_inc > cfg.hold_checks && cfg.hold_enable)
                    s.button = BTN_HELD;
            end
            else
            begin
                if (st.key_down_cnt > 16'd1)
                begin
                    priority if (st.button == BTN_HELD)
                    begin
                        s.button = BTN_RELEASED;
                        s.dclick_cnt = 8'd0;
                    end
                    else if (st.dclick_cnt > 8'd1)
                    begin
                        if (st.dclick_cnt < cfg.double_click_checks)
                        begin
                            s.button = BTN_DOUBLE;
                            s.dclick_cnt = 8'd0;
                        end
                    end
                    else
                    begin
                        s.dclick_cnt = cfg.double_click_enable ? cfg.double_click_checks
                                                               : 8'd1;
                    end
                end
                s.key_down_cnt = 16'd0;
            end
            if (s.dclick_cnt != 8'd0)
            begin
                s.dclick_cnt = s.dclick_cnt - 8'd1;
                if (s.dclick_cnt == 8'd0)
                    s.button = BTN_CLICKED;
            end
        end

        // value take: whole notches only
        neg = s.step_delta[15];
        pos = !neg && (cfg.half_step_mode ? (s.step_delta[15:1] != 15'd0)
                                          : (s.step_delta[15:2] != 14'd0));
        mag = 7'd1 + (cfg.accel_enable ? {1'b0, s.accel[11:6]} : 7'd0);
        rotation_step = '0;
        if (take_value)
        begin
            s.step_delta = cfg.half_step_mode ? {15'd0, s.step_delta[0]}
                                              : {14'd0, s.step_delta[1:0]};
            priority if (neg)
                rotation_step = -$signed(mag);
            else if (pos)
                rotation_step = $signed(mag);
            else
                rotation_step = '0;
        end

        button_event = 3'd0;
        if (take_event)
        begin
            button_event = s.button;
            if (s.button != BTN_HELD && s.button != BTN_OPEN)
                s.button = BTN_OPEN;
        end

        st_next = s;
    end

endmodule

/* sv/rotary_encoder_accel_click_top.sv */
// Top level of the rotary encoder with acceleration and click detection.
// Holds config, state and result registers; uses reac_pkg, reac_if, reac_step.
//
//   port    | dir | beat contents
//   item    | in  | phase_a_level, phase_b_level, key_level, take_value, take_event
//   result  | out | rotation_step, button_event
//   cfg     | in  | index, data (register write, always ready)
//
// One tick per cycle; the result of a beat is registered and shown the next cycle.
// item.ready is low only while a result waits and result.ready is low.
// The single state update lies between the input and the result register.
// rst_n clears state, config to defaults and the result valid bit at once.
module rotary_encoder_accel_click_top
    import reac_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    reac_in_if.sink        item,
    reac_out_if.source     result,
    reac_cfg_if.sink       cfg
);

    reac_cfg_t         cfg_reg;
    reac_state_t       state_reg;
    reac_state_t       state_next;
    logic              res_valid_reg;
    logic signed [6:0] rot_reg;
    logic signed [6:0] rot_next;
    logic [2:0]        evt_reg;
    logic [2:0]        evt_next;
    logic              in_accept;

    assign in_accept  = item.valid && item.ready;
    assign item.ready = !res_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid         = res_valid_reg;
    assign result.rotation_step = rot_reg;
    assign result.button_event  = evt_reg;

    reac_step u_step (
        .st            (state_reg),
        .cfg           (cfg_reg),
        .phase_a_level (item.phase_a_level),
        .phase_b_level (item.phase_b_level),
        .key_level     (item.key_level),
        .take_value    (item.take_value),
        .take_event    (item.take_event),
        .st_next       (state_next),
        .rotation_step (rot_next),
        .button_event  (evt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_step_mode      <= 1'b0;
            cfg_reg.accel_increment     <= ACCEL_INC_RST;
            cfg_reg.accel_enable        <= 1'b1;
            cfg_reg.double_click_enable <= 1'b1;
            cfg_reg.hold_enable         <= 1'b1;
            cfg_reg.check_interval      <= 8'd10;
            cfg_reg.hold_checks         <= 16'd120;
            cfg_reg.double_click_checks <= 8'd60;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_HALF_STEP:    cfg_reg.half_step_mode      <= cfg.data[0];
                CFG_ACCEL_INC:    cfg_reg.accel_increment     <= cfg.data[11:0];
                CFG_ACCEL_EN:     cfg_reg.accel_enable        <= cfg.data[0];
                CFG_DCLICK_EN:    cfg_reg.double_click_enable <= cfg.data[0];
                CFG_HOLD_EN:      cfg_reg.hold_enable         <= cfg.data[0];
                CFG_INTERVAL:     cfg_reg.check_interval      <= cfg.data[7:0];
                CFG_HOLD_CHECKS:  cfg_reg.hold_checks         <= cfg.data[15:0];
                CFG_DCLICK_CHECK: cfg_reg.double_click_checks <= cfg.data[7:0];
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_phase   <= 2'd0;
            state_reg.step_delta   <= 16'd0;
            state_reg.accel        <= 12'd0;
            state_reg.interval_cnt <= 8'd0;
            state_reg.key_down_cnt <= 16'd0;
            state_reg.dclick_cnt   <= 8'd0;
            state_reg.button       <= BTN_OPEN;
            res_valid_reg          <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg     <= state_next;
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rot_reg <= rot_next;
            evt_reg <= evt_next;
        end
    end

    a_accel_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.accel <= ACCEL_TOP)
        else $error("acceleration above cap");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.rotation_step <= 7'sd49 && result.rotation_step >= -7'sd49))
        else $error("rotation step out of range");

    a_no_take_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !item.take_value && !item.take_event) |=>
        (result.rotation_step == 7'sd0 && result.button_event == 3'd0))
        else $error("result without take");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> result.valid)
        else $error("accepted beat gave no result");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Testbench for rotary_encoder_accel_click_top: directed and random ticks checked
// against an in-bench encoder/button predictor. Uses reac_pkg and the reac_if interfaces.
module testbench;
    import reac_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        logic signed [6:0] rotation;
        logic [2:0]        event_code;
    } knob_result_t;

    logic clk;
    logic rst_n;

    reac_in_if  item();
    reac_out_if result();
    reac_cfg_if cfg();

    rotary_encoder_accel_click_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    reac_cfg_t    knob_cfg;
    logic [1:0]   enc_phase;
    logic [15:0]  step_count;
    logic [11:0]  accel_level;
    logic [7:0]   tick_count;
    logic [15:0]  press_count;
    logic [7:0]   dclick_window;
    btn_t         button_now;

    knob_result_t expected_results[$];
    int           err_count;
    int           ticks_sent;
    int           results_checked;
    int           settings_used;
    int           rotations_seen;
    int           event_seen[5];
    bit           steady;
    int           knob_pos;
    int           idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic reset_model();
        knob_cfg.half_step_mode      = 1'b0;
        knob_cfg.accel_increment     = ACCEL_INC_RST;
        knob_cfg.accel_enable        = 1'b1;
        knob_cfg.double_click_enable = 1'b1;
        knob_cfg.hold_enable         = 1'b1;
        knob_cfg.check_interval      = 8'd10;
        knob_cfg.hold_checks         = 16'd120;
        knob_cfg.double_click_checks = 8'd60;
        enc_phase     = '0;
        step_count    = '0;
        accel_level   = '0;
        tick_count    = '0;
        press_count   = '0;
        dclick_window = '0;
        button_now    = BTN_OPEN;
    endtask

    function automatic knob_result_t predict_tick(input logic a, input logic b, input logic key,
                                                  input logic tv, input logic te);
        knob_result_t r;
        logic [1:0]   curr;
        logic [1:0]   diff;
        logic [6:0]   mag;
        logic         neg;
        logic         pos;
        r.rotation   = '0;
        r.event_code = BTN_OPEN;
        accel_level = (accel_level >= ACCEL_DEC) ? accel_level - ACCEL_DEC : 12'd0;

        curr = a ? 2'd0 : 2'd3;
        if (!b)
            curr = curr ^ 2'd1;
        diff = enc_phase - curr;
        if (diff[0])
        begin
            enc_phase  = curr;
            step_count = step_count + 16'(diff & 2'd2) - 16'd1;
            if (int'(accel_level) + int'(knob_cfg.accel_increment) <= int'(ACCEL_TOP))
                accel_level = accel_level + knob_cfg.accel_increment;
        end

        if (tick_count != 8'hFF)
            tick_count++;
        if (tick_count >= knob_cfg.check_interval)
        begin
            tick_count = '0;
            if (!key)
            begin
                if (press_count != 16'hFFFF)
                    press_count++;
                if (press_count > knob_cfg.hold_checks && knob_cfg.hold_enable)
                    button_now = BTN_HELD;
            end
            else
            begin
                if (press_count > 16'd1)
                begin
                    if (button_now == BTN_HELD)
                    begin
                        button_now    = BTN_RELEASED;
                        dclick_window = '0;
                    end
                    else if (dclick_window > 8'd1)
                    begin
                        if (dclick_window < knob_cfg.double_click_checks)
                        begin
                            button_now    = BTN_DOUBLE;
                            dclick_window = '0;
                        end
                    end
                    else
                        dclick_window = knob_cfg.double_click_enable ?
                                        knob_cfg.double_click_checks : 8'd1;
                end
                press_count = '0;
            end
            if (dclick_window != 8'd0)
            begin
                dclick_window--;
                if (dclick_window == 8'd0)
                    button_now = BTN_CLICKED;
            end
        end

        if (tv)
        begin
            neg = step_count[15];
            pos = !neg && ((step_count >> (knob_cfg.half_step_mode ? 1 : 2)) != 16'd0);
            mag = 7'd1 + (knob_cfg.accel_enable ? 7'(accel_level >> 6) : 7'd0);
            step_count = step_count & (knob_cfg.half_step_mode ? 16'd1 : 16'd3);
            if (neg)
                r.rotation = 7'd0 - mag;
            else if (pos)
                r.rotation = mag;
        end

        if (te)
        begin
            r.event_code = button_now;
            if (button_now != BTN_HELD && button_now != BTN_OPEN)
                button_now = BTN_OPEN;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s, got %0d, expected %0d",
                 results_checked, what, got, want);
        err_count++;
    endtask

    task automatic send_tick(input logic a, input logic b, input logic key,
                             input logic tv, input logic te);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid         <= 1'b1;
        item.phase_a_level <= a;
        item.phase_b_level <= b;
        item.key_level     <= key;
        item.take_value    <= tv;
        item.take_event    <= te;
        do @(posedge clk); while (!item.ready);
        expected_results.push_back(predict_tick(a, b, key, tv, te));
        ticks_sent++;
    endtask

    task automatic turn(input int dir, input logic key, input logic tv, input logic te);
        knob_pos = (knob_pos + dir) & 3;
        send_tick(knob_pos < 2, knob_pos == 0 || knob_pos == 3, key, tv, te);
    endtask

    task automatic settle();
        item.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_HALF_STEP:    knob_cfg.half_step_mode      = value[0];
            CFG_ACCEL_INC:    knob_cfg.accel_increment     = value[11:0];
            CFG_ACCEL_EN:     knob_cfg.accel_enable        = value[0];
            CFG_DCLICK_EN:    knob_cfg.double_click_enable = value[0];
            CFG_HOLD_EN:      knob_cfg.hold_enable         = value[0];
            CFG_INTERVAL:     knob_cfg.check_interval      = value[7:0];
            CFG_HOLD_CHECKS:  knob_cfg.hold_checks         = value;
            CFG_DCLICK_CHECK: knob_cfg.double_click_checks = value[7:0];
        endcase
    endtask

    task automatic set_config(input logic half, input logic [11:0] inc, input logic aen,
                              input logic den, input logic hen, input logic [7:0] ivl,
                              input logic [15:0] hold, input logic [7:0] dck);
        settle();
        write_reg(CFG_HALF_STEP, 16'(half));
        write_reg(CFG_ACCEL_INC, 16'(inc));
        write_reg(CFG_ACCEL_EN, 16'(aen));
        write_reg(CFG_DCLICK_EN, 16'(den));
        write_reg(CFG_HOLD_EN, 16'(hen));
        write_reg(CFG_INTERVAL, 16'(ivl));
        write_reg(CFG_HOLD_CHECKS, hold);
        write_reg(CFG_DCLICK_CHECK, 16'(dck));
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_default_settings();
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b1, 1'b1);
        // one step back wraps the count below zero
        turn(-1, 1'b1, 1'b1, 1'b0);
        turn(0, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_rotation_modes();
        set_config(1'b1, 12'hFFF, 1'b0, 1'b1, 1'b1, 8'd10, 16'd120, 8'd60);
        turn(-1, 1'b1, 1'b0, 1'b0);
        turn(-1, 1'b1, 1'b1, 1'b0);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b1, 1'b0);
        set_config(1'b0, 12'd3072, 1'b1, 1'b1, 1'b1, 8'd10, 16'd120, 8'd60);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b0, 1'b0);
        turn(1, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_button_events();
        // interval zero: a check on every tick
        set_config(1'b0, 12'd80, 1'b1, 1'b1, 1'b1, 8'd0, 16'd2, 8'd1);
        turn(0, 1'b0, 1'b0, 1'b0);
        turn(0, 1'b0, 1'b0, 1'b0);
        turn(0, 1'b0, 1'b0, 1'b1);
        turn(0, 1'b1, 1'b0, 1'b1);
        turn(0, 1'b0, 1'b0, 1'b0);
        turn(0, 1'b0, 1'b0, 1'b0);
        turn(0, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_counter_limits();
        // long press past the hold threshold while turning, then release
        set_config(1'b0, 12'd1, 1'b1, 1'b1, 1'b1, 8'd1, 16'd40, 8'd60);
        steady = 1'b1;
        for (int i = 0; i < 100; i++)
            turn(1, 1'b0, i == 40 || i == 99, (i % 16) == 0);
        turn(0, 1'b1, 1'b0, 1'b1);
        steady = 1'b0;
    endtask

    task automatic random_ticks(input int count);
        int   dir;
        int   key_left;
        int   scale;
        int   r;
        logic key;
        logic a;
        logic b;
        logic tv;
        logic te;
        scale    = (knob_cfg.check_interval == 8'd0) ? 1 : int'(knob_cfg.check_interval);
        dir      = 1;
        key      = 1'b1;
        key_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (key_left == 0)
            begin
                key      = ~key;
                key_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) * scale
                                                       : $urandom_range(1, 6) * scale;
            end
            key_left--;
            if ($urandom_range(0, 31) == 0)
                dir = -dir;
            if ($urandom_range(0, 63) == 0)
                steady = !steady;
            if ($urandom_range(0, 99) == 0)
                settle();
            tv = ($urandom_range(0, 3) == 0);
            te = ($urandom_range(0, 2) == 0);
            r  = $urandom_range(0, 15);
            if (r == 0)
            begin
                // encoder noise: arbitrary levels
                a = 1'($urandom_range(0, 1));
                b = 1'($urandom_range(0, 1));
                knob_pos = a ? (b ? 0 : 1) : (b ? 3 : 2);
                send_tick(a, b, key, tv, te);
            end
            else
                turn(r < 9 ? dir : 0, key ^ ($urandom_range(0, 31) == 0), tv, te);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_settings();
        set_config(1'b0, 12'd80, 1'b1, 1'b1, 1'b1, 8'd1, 16'd12, 8'd6);
        random_ticks(200);
        set_config(1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 8'd2, 16'd3, 8'd2);
        random_ticks(200);
        set_config(1'b0, 12'hFFF, 1'b1, 1'b1, 1'b1, 8'd255, 16'd1, 8'd255);
        random_ticks(200);
        set_config(1'b1, 12'd3072, 1'b1, 1'b1, 1'b1, 8'd0, 16'd65534, 8'd0);
        random_ticks(200);
        set_config(1'b0, 12'd200, 1'b1, 1'b1, 1'b0, 8'd3, 16'd1, 8'd255);
        random_ticks(200);
        set_config(1'b1, 12'd37, 1'b1, 1'b1, 1'b1, 8'd1, 16'd5, 8'd3);
        random_ticks(200);
    endtask

    // result checker
    initial
    begin
        knob_result_t want;
        int           stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", int'(result.button_event), 0);
            else
            begin
                want = expected_results.pop_front();
                if (result.rotation_step !== want.rotation)
                    report_mismatch("rotation_step", int'(result.rotation_step),
                                    int'(want.rotation));
                if (result.button_event !== want.event_code)
                    report_mismatch("button_event", int'(result.button_event),
                                    int'(want.event_code));
                event_seen[want.event_code]++;
                if (want.rotation != 7'sd0)
                    rotations_seen++;
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        item.valid         <= 1'b0;
        item.phase_a_level <= 1'b1;
        item.phase_b_level <= 1'b1;
        item.key_level     <= 1'b1;
        item.take_value    <= 1'b0;
        item.take_event    <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.index          <= CFG_HALF_STEP;
        cfg.data           <= '0;
        reset_model();
        steady   = 1'b0;
        knob_pos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_rotation_modes();
        test_button_events();
        test_counter_limits();
        test_random_settings();

        settle();
        repeat (4) @(posedge clk);
        while (expected_results.size() != 0)
        begin
            report_mismatch("result never arrived", 0,
                            int'(expected_results[0].event_code));
            void'(expected_results.pop_front());
        end

        $display("covered %0d ticks, %0d results checked, %0d register settings",
                 ticks_sent, results_checked, settings_used);
        $display("events: %0d clicked, %0d double, %0d held, %0d released; %0d rotations",
                 event_seen[BTN_CLICKED], event_seen[BTN_DOUBLE], event_seen[BTN_HELD],
                 event_seen[BTN_RELEASED], rotations_seen);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/reac_pkg.sv
sv/reac_if.sv
sv/reac_step.sv
sv/rotary_encoder_accel_click_top.sv
verif/testbench.sv
